### design/assert_macros.svh
// Assertion macros shared by the RTL.
// Each one is evaluated on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge.
`define LBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that trig on one edge implies cons on the next edge.
`define LBP_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);
`else
`define LBP_ASSERT(label, prop, msg)
`define LBP_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

### design/lbp_pkg.sv
`default_nettype none
package lbp_pkg;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	localparam int                APB_AW        = 3;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'h0;
	localparam logic [14:0]       CAP_RESET     = 15'd16384;
	localparam logic [3:0]        MAX_BITS      = 4'd8;

endpackage
`default_nettype wire

### design/lbp_store.sv
`default_nettype none
module lbp_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### design/lsb_first_bit_packer.sv
// Channel  Dir  Width  Contents
// s        in   24+1   item: tdata data, bit_count, byte_address; tuser cmd
// m        out  24     result: read_data, bit_head, overflow
// apb      in   32     capacity_bits at 0x0
//
// The accept cycle reads the byte under the head (or the requested byte) from
// the store; the merge stage merges it and writes it back once it may advance.
// A field that crosses into the next byte writes that byte in the accept cycle.
// Reset clears the head and the valid flags; the store is not swept, and bytes
// at or beyond the head read as zero. No item is taken while the merge stage
// is full, so a result waiting in m holds back a further item only then.
`default_nettype none
`include "assert_macros.svh"
module lsb_first_bit_packer import lbp_pkg::*; #(
	parameter int BUFFER_BYTES = 2048
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [23:0]       s_tdata,  // data[7:0], bit_count[11:8], byte_address[22:12]
	input  wire logic              s_tuser,  // cmd
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [23:0]       m_tdata,  // read_data[7:0], bit_head[22:8], overflow[23]
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int          AW         = $clog2(BUFFER_BYTES);
	localparam logic [31:0] STORE_BITS = 32'(BUFFER_BYTES) * 32'd8;

	logic [14:0] cap_q;
	logic [14:0] head_q;
	logic        valid_s1;
	logic        out_valid_q;
	logic [23:0] out_data_q;

	logic        wr_s1;
	logic        old_ok_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]  mask_s1;
	logic [7:0]  bits_s1;
	logic        rd_s1;
	logic        rd_ok_s1;
	logic [14:0] head_s1;
	logic        ovf_s1;

	cmd_t        in_cmd;
	logic [7:0]  in_data;
	logic [3:0]  in_cnt;
	logic [10:0] in_addr;
	logic [3:0]  cnt_sat;
	logic [15:0] next_head;
	logic [31:0] usable;
	logic        is_wr;
	logic        ovf;
	logic        do_wr;
	logic [2:0]  off;
	logic [7:0]  mask8;
	logic [15:0] mask16;
	logic [15:0] bits16;
	logic        straddle;
	logic [31:0] idx32;
	logic [31:0] idx_next32;
	logic [31:0] rd_addr32;
	logic [AW-1:0] rd_addr;
	logic        rd_ok;
	logic        accept;
	logic        adv_s1;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]  mem_wdata;
	logic [7:0]  mem_rd;
	logic [7:0]  merged;
	logic [7:0]  out_rd;
	logic        cfg_wr;
	logic        cfg_hit;

	assign in_cmd  = cmd_t'(s_tuser);
	assign in_data = s_tdata[7:0];
	assign in_cnt  = s_tdata[11:8];
	assign in_addr = s_tdata[22:12];

	assign cnt_sat   = (in_cnt > MAX_BITS) ? MAX_BITS : in_cnt;
	assign next_head = {1'b0, head_q} + 16'(cnt_sat);
	assign usable    = (32'(cap_q) < STORE_BITS) ? 32'(cap_q) : STORE_BITS;
	assign is_wr     = (in_cmd == CMD_WRITE);
	assign ovf       = is_wr && (cnt_sat != 4'd0) && (32'(next_head) > usable);
	assign do_wr     = is_wr && (cnt_sat != 4'd0) && !ovf;

	assign off      = head_q[2:0];
	assign mask8    = 8'((9'd1 << cnt_sat) - 9'd1);
	assign mask16   = 16'(mask8) << off;
	assign bits16   = 16'(in_data & mask8) << off;
	assign straddle = |mask16[15:8];

	assign idx32      = 32'(head_q[14:3]);
	assign idx_next32 = idx32 + 32'd1;
	assign rd_addr32  = 32'(in_addr);
	assign rd_addr    = is_wr ? idx32[AW-1:0] : rd_addr32[AW-1:0];
	assign rd_ok      = 15'({in_addr, 3'b000}) < head_q;

	assign s_tready = !valid_s1;
	assign accept   = s_tvalid && s_tready;
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);

	// the far byte of a crossing field is fresh, so it is written whole
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = merged;
		if (accept && do_wr && straddle) begin
			mem_we    = 1'b1;
			mem_waddr = idx_next32[AW-1:0];
			mem_wdata = bits16[15:8];
		end else if (adv_s1 && wr_s1) begin
			mem_we = 1'b1;
		end
	end

	assign merged = ((old_ok_s1 ? mem_rd : 8'h00) & ~mask_s1) | bits_s1;
	assign out_rd = (rd_s1 && rd_ok_s1) ? mem_rd : 8'h00;

	lbp_store #(
		.DEPTH(BUFFER_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(mem_rd)
	);

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_hit = ({paddr[2], 2'b00} == ADDR_CAPACITY);
	assign prdata  = cfg_hit ? 32'(cap_q) : 32'd0;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			head_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && cfg_hit) begin
				cap_q <= pwdata[14:0];
			end
			if (accept && do_wr) begin
				head_q <= next_head[14:0];
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1     <= do_wr;
			old_ok_s1 <= (off != 3'd0);
			addr_s1   <= idx32[AW-1:0];
			mask_s1   <= mask16[7:0];
			bits_s1   <= bits16[7:0];
			rd_s1     <= !is_wr;
			rd_ok_s1  <= rd_ok;
			head_s1   <= do_wr ? next_head[14:0] : head_q;
			ovf_s1    <= ovf;
		end
		if (adv_s1) begin
			out_data_q <= {ovf_s1, head_s1, out_rd};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`LBP_ASSERT_NEXT(a_accept_fills, accept, valid_s1, "accepted item did not reach merge stage")
	`LBP_ASSERT_NEXT(a_stall_holds, valid_s1 && out_valid_q && !m_tready, valid_s1, "merge stage lost an item")
	`LBP_ASSERT_NEXT(a_head_mono, 1'b1, head_q >= $past(head_q), "bit head moved back")
	`LBP_ASSERT(a_head_fits, (head_q != $past(head_q)) |-> (32'(head_q) <= usable), "bit head past capacity")

endmodule
`default_nettype wire
